### hdl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Types and codes shared by the bounded position deque core and its cells.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int SIZE_W  = 9;
    localparam int INDEX_W = 9;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_RM_HEAD  = 3'd2,
        OP_RM_TAIL  = 3'd3,
        OP_RD_HEAD  = 3'd4,
        OP_RD_TAIL  = 3'd5,
        OP_RD_INDEX = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_SWEEP = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] symbol;
    } entry_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
        logic [7:0]         pos_symbol;
        logic [INDEX_W-1:0] slot_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        out_x;
        logic [7:0]        out_y;
        logic [7:0]        out_symbol;
        logic [SIZE_W-1:0] list_size;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic ins_head;
        logic ins_tail;
        logic rm_head;
    } cell_ctrl_t;

endpackage

### hdl/bounded_position_deque_core.sv
// ----------------------------------------------------------------------------
// bounded_position_deque_core
// Fixed-capacity deque of position entries built as a row of shifting cells.
//
//   channel  | signals              | transaction
//   ---------+----------------------+-------------------------------------
//   command  | start, busy, cmd     | start high while busy low
//   result   | done, rsp            | done high for one cycle, no backpressure
//
// Inserts, removals and refused operations return their result the cycle
// after the command, and a new command can follow at once.
// A successful read sweeps the cell row: the entry travels down the
// read bus of the cell row one slot per cycle, and busy stays high meanwhile.
// Reset clears every slot and the size at once.
// ----------------------------------------------------------------------------
module bounded_position_deque_core
    import bpd_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    fsm_state_t       state_reg;
    fsm_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] tgt_reg;
    logic [IDX_W-1:0] tgt_next;
    logic [CNT_W-1:0] sweep_reg;
    logic [CNT_W-1:0] sweep_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             done_reg;
    logic             done_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             rd_go;
    status_t          st;
    cell_ctrl_t       ctrl;
    entry_t           item;
    entry_t           ent [CAPACITY];
    entry_t           bus [CAPACITY+1];

    assign busy   = (state_reg != FSM_IDLE);
    assign accept = start && (state_reg == FSM_IDLE);
    assign full   = (count_reg >= CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign item   = '{x: cmd.pos_x, y: cmd.pos_y, symbol: cmd.pos_symbol};

    // decode the command
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        tgt_next   = tgt_reg;
        rd_go      = 1'b0;
        st         = ST_OK;
        unique case (opcode_t'(cmd.opcode))
            OP_INS_HEAD:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    ctrl.ins_head = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_INS_TAIL:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    ctrl.ins_tail = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_RM_HEAD:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    ctrl.rm_head = accept;
                    count_next   = count_reg - 1'b1;
                end
            end
            OP_RM_TAIL:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            OP_RD_HEAD:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_go    = 1'b1;
                    tgt_next = '0;
                end
            end
            OP_RD_TAIL:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_go    = 1'b1;
                    tgt_next = IDX_W'(count_reg - 1'b1);
                end
            end
            OP_RD_INDEX:
            begin
                if (32'(cmd.slot_index) >= CAPACITY)
                begin
                    st = ST_BAD_INDEX;
                end
                else
                begin
                    rd_go    = 1'b1;
                    tgt_next = IDX_W'(cmd.slot_index);
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept && rd_go)
                begin
                    state_next = FSM_SWEEP;
                end
            end
            FSM_SWEEP:
            begin
                if (sweep_reg == '0)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb
    begin
        rsp_next   = '0;
        done_next  = 1'b0;
        sweep_next = sweep_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                sweep_next = CNT_W'(CAPACITY);
                if (accept && !rd_go)
                begin
                    done_next          = 1'b1;
                    rsp_next.list_size = SIZE_W'(count_next);
                    rsp_next.status    = st;
                end
            end
            FSM_SWEEP:
            begin
                sweep_next = sweep_reg - 1'b1;
                if (sweep_reg == '0)
                begin
                    done_next           = 1'b1;
                    rsp_next.out_x      = bus[0].x;
                    rsp_next.out_y      = bus[0].y;
                    rsp_next.out_symbol = bus[0].symbol;
                    rsp_next.list_size  = SIZE_W'(count_reg);
                    rsp_next.status     = ST_OK;
                end
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= accept ? count_next : count_reg;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            tgt_reg <= tgt_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign bus[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        entry_t left_in;
        entry_t right_in;

        if (g == 0)
        begin : g_first
            assign left_in = item;
        end
        else
        begin : g_mid
            assign left_in = ent[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_body
            assign right_in = ent[g+1];
        end

        bpd_cell #(
            .INDEX (g),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .tgt       (tgt_reg),
            .item      (item),
            .left_in   (left_in),
            .right_in  (right_in),
            .bus_in    (bus[g+1]),
            .entry_out (ent[g]),
            .bus_out   (bus[g])
        );
    end

endmodule

### hdl/bpd_cell.sv
// ----------------------------------------------------------------------------
// bpd_cell
// One slot of the deque: holds an entry, shifts with its neighbors on head
// inserts and removals, and forwards a read bus toward slot zero.
// ----------------------------------------------------------------------------
module bpd_cell
    import bpd_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 9,
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] tgt,
    input  entry_t           item,
    input  entry_t           left_in,
    input  entry_t           right_in,
    input  entry_t           bus_in,
    output entry_t           entry_out,
    output entry_t           bus_out
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t bus_reg;
    entry_t bus_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_head && (CNT_W'(INDEX) <= count))
        begin
            entry_next = left_in;
        end
        else if (ctrl.ins_tail && (CNT_W'(INDEX) == count))
        begin
            entry_next = item;
        end
        else if (ctrl.rm_head && (CNT_W'(INDEX + 1) < count))
        begin
            entry_next = right_in;
        end
    end

    always_comb
    begin
        bus_next = (IDX_W'(INDEX) == tgt) ? entry_reg : bus_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign entry_out = entry_reg;
    assign bus_out   = bus_reg;

endmodule
